@@ hdl/firc_pkg.sv @@
// Shared constants, coefficient table and helper for the circular-buffer FIR filter.
package firc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int ROUND_SHIFT = COEF_BITS - 1;
	localparam int ROM_TAPS    = 47;
	localparam int TAP_IDX_W   = 8;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam coef_t COEF_ROM [ROM_TAPS] = '{
		16'sd57, 16'sd50, -16'sd74, -16'sd35, 16'sd129, 16'sd7, -16'sd205, 16'sd77,
		16'sd269, -16'sd220, -16'sd299, 16'sd438, 16'sd239, -16'sd717, -16'sd39,
		16'sd1036, -16'sd388, -16'sd1354, 16'sd1191, 16'sd1629, -16'sd2893,
		-16'sd1813, 16'sd10227, 16'sd18263, 16'sd10227, -16'sd1813, -16'sd2893,
		16'sd1629, 16'sd1191, -16'sd1354, -16'sd388, 16'sd1036, -16'sd39,
		-16'sd717, 16'sd239, 16'sd438, -16'sd299, -16'sd220, 16'sd269, 16'sd77,
		-16'sd205, 16'sd7, 16'sd129, -16'sd35, -16'sd74, 16'sd50, 16'sd57
	};

	// Taps past the end of the table have a zero coefficient.
	function automatic coef_t coef_at(input logic [TAP_IDX_W-1:0] k);
		coef_t c;
		c = '0;
		if (k < TAP_IDX_W'(ROM_TAPS)) begin
			c = COEF_ROM[k[5:0]];
		end
		return c;
	endfunction

endpackage

@@ hdl/fir_filter_circular_unit.sv @@
// Top level of the FIR filter with a circular delay line and one shared multiply-accumulate.
//
//  Channel | Signals                        | Word
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, sample     | one signed Q15 sample
//  output  | out_valid, out_ready, filtered | one rounded, saturated Q15 sum
//
// Each sample takes one multiply-accumulate per tap and is done before the next is taken in.
// The tap loop runs through a read, multiply and accumulate pipeline of three stages.
// Reset clears the delay line at once through one valid bit per entry.
// A waiting result holds in the output register while the next sample is taken in;
// that sample's result is only written once the earlier one has left.
module fir_filter_circular_unit #(
	parameter int TAPS = 47
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [firc_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [firc_pkg::SAMPLE_BITS-1:0] filtered
);

	localparam int PW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = firc_pkg::PROD_BITS + PW + 1;
	localparam int SB    = firc_pkg::SAMPLE_BITS;
	localparam int PB    = firc_pkg::PROD_BITS;

	localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (firc_pkg::ROUND_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX   = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_MIN   = -SAT_MAX - ACC_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                         state_q;
	logic [PW-1:0]                  wp_q;
	logic [PW-1:0]                  pos_q;
	logic [PW-1:0]                  k_q;
	logic [TAPS-1:0]                valid_q;
	logic                           out_valid_q;
	logic signed [SB-1:0]           filtered_q;

	logic                           iss_s1;
	logic                           vld_s1;
	firc_pkg::coef_t                coef_s1;
	logic                           prd_s2;
	logic signed [PB-1:0]           prod_s2;
	logic signed [ACC_W-1:0]        acc_q;

	logic                           accept;
	logic [PW-1:0]                  wp_next;
	logic [PW-1:0]                  pos_next;
	logic [SB-1:0]                  rdata;
	logic signed [SB-1:0]           tap_sample;
	logic signed [ACC_W-1:0]        rounded;
	logic signed [ACC_W-1:0]        shifted;
	logic signed [SB-1:0]           sat_result;
	logic                           finish;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	assign wp_next  = (wp_q == PW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign pos_next = (pos_q == '0) ? PW'(TAPS - 1) : pos_q - 1'b1;

	firc_ram #(
		.WIDTH (SB),
		.DEPTH (TAPS)
	) u_delay_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_next),
		.wdata (sample),
		.raddr (pos_q),
		.rdata (rdata)
	);

	assign tap_sample = vld_s1 ? $signed(rdata) : '0;

	always_comb begin
		rounded = acc_q + ROUND_ADD;
		shifted = rounded >>> firc_pkg::ROUND_SHIFT;
		if (shifted > SAT_MAX) begin
			sat_result = SAT_MAX[SB-1:0];
		end else if (shifted < SAT_MIN) begin
			sat_result = SAT_MIN[SB-1:0];
		end else begin
			sat_result = shifted[SB-1:0];
		end
	end

	assign finish = (state_q == ST_DRAIN) && !iss_s1 && !prd_s2
		&& (!out_valid_q || out_ready);

	// Datapath pipeline: coefficient and entry lookup, product, accumulation.
	always_ff @(posedge clk) begin
		coef_s1 <= firc_pkg::coef_at(firc_pkg::TAP_IDX_W'(k_q));
		vld_s1  <= valid_q[pos_q];
		prod_s2 <= coef_s1 * tap_sample;
		if (accept) begin
			acc_q <= '0;
		end else if (prd_s2) begin
			acc_q <= acc_q + {{(ACC_W - PB){prod_s2[PB-1]}}, prod_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			valid_q     <= '0;
			iss_s1      <= 1'b0;
			prd_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
		end else begin
			iss_s1 <= (state_q == ST_RUN);
			prd_s2 <= iss_s1;
			if (out_valid_q && out_ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q             <= wp_next;
						pos_q            <= wp_next;
						k_q              <= '0;
						valid_q[wp_next] <= 1'b1;
						state_q          <= ST_RUN;
					end
				end
				ST_RUN: begin
					pos_q <= pos_next;
					k_q   <= k_q + 1'b1;
					if (k_q == PW'(TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						filtered_q  <= sat_result;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q <= PW'(TAPS - 1)) && (pos_q <= PW'(TAPS - 1)))
		else $error("Delay line position out of range.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (k_q == '0) && (pos_q == wp_q))
		else $error("Accepted word did not start the tap walk at the write position.");

	a_entry_marked: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_q[wp_q])
		else $error("Written delay line entry is not marked valid.");

	a_issue_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		iss_s1 |-> $past(state_q) == ST_RUN)
		else $error("Tap issued outside the run state.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(filtered_q))
		else $error("Waiting result was overwritten or dropped.");
`endif

endmodule

@@ hdl/firc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module firc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 47
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
